FILE: rtl/core/npcm_pkg.sv
// Shared types and constants of the nearest palette color mapper.
package npcm_pkg;

	localparam int PALETTE_DEPTH_DEF = 16;
	localparam int COLOR_W = 8;
	localparam int IDX_W = 4;
	localparam int COUNT_W = 5;
	localparam int DIST_W = 18;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 40;
	localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	localparam logic REG_PALETTE_COUNT = 1'b0;
	localparam logic REG_NEAR_ENOUGH = 1'b1;
	localparam logic [DIST_W-1:0] NEAR_ENOUGH_RST = 18'd6;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic mode;
		logic [IDX_W-1:0] idx;
		rgb_t pixel;
		logic [COLOR_W-1:0] alpha;
		logic found;
		logic stop;
		logic [IDX_W-1:0] best_idx;
		rgb_t best_rgb;
		logic [DIST_W-1:0] best_dist;
	} beat_t;

endpackage

FILE: rtl/core/npcm_cell.sv
// One palette cell: holds one entry, scores the passing pixel and keeps the best match.
module npcm_cell #(
	parameter int CELL_INDEX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic [npcm_pkg::COUNT_W-1:0] count,
	input logic [npcm_pkg::DIST_W-1:0] near_enough_sq,
	input logic in_valid,
	input npcm_pkg::beat_t in_beat,
	output logic out_valid,
	output npcm_pkg::beat_t out_beat
);
	import npcm_pkg::*;

	function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
			input logic [COLOR_W-1:0] b);
		logic [COLOR_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return (2*COLOR_W)'(d) * (2*COLOR_W)'(d);
	endfunction

	rgb_t entry_q;
	logic active;
	logic [DIST_W-1:0] sum_sq;
	logic valid_s1;
	logic active_s1;
	beat_t beat_s1;
	logic [DIST_W-1:0] dist_s1;
	logic valid_s2;
	beat_t beat_s2;
	beat_t next_beat;
	logic take;

	assign active = CELL_INDEX < int'(count);
	assign sum_sq = DIST_W'(sq_diff(entry_q.red, in_beat.pixel.red))
		+ DIST_W'(sq_diff(entry_q.green, in_beat.pixel.green))
		+ DIST_W'(sq_diff(entry_q.blue, in_beat.pixel.blue));

	always_ff @(posedge clk) begin
		if (advance && in_valid && in_beat.mode == MODE_LOAD
				&& int'(in_beat.idx) == CELL_INDEX) begin
			entry_q <= in_beat.pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_s1 <= in_beat;
			dist_s1 <= sum_sq;
			active_s1 <= active;
			beat_s2 <= next_beat;
		end
	end

	always_comb begin
		next_beat = beat_s1;
		take = 1'b0;
		if (active_s1 && beat_s1.mode == MODE_PIXEL && !beat_s1.stop) begin
			take = !beat_s1.found || dist_s1 < beat_s1.best_dist;
			if (take) begin
				next_beat.found = 1'b1;
				next_beat.best_idx = IDX_W'(CELL_INDEX);
				next_beat.best_rgb = entry_q;
				next_beat.best_dist = dist_s1;
			end
			next_beat.stop = next_beat.best_dist <= near_enough_sq;
		end
	end

	assign out_valid = valid_s2;
	assign out_beat = beat_s2;

endmodule

FILE: rtl/core/nearest_palette_color_mapper_core.sv
// Nearest palette color mapper: a chain of palette cells, one per entry, and an output register.
// Palette entries load as beats with mode 0 and travel down the chain in stream order, so a
// load takes effect for exactly the pixels behind it. Each pixel beat passes through every cell,
// two register stages per cell (squared distance, then best-match update), and then into the output
// register; one beat is accepted every cycle while the output side takes results. Load beats give
// no result. The whole chain holds while a result waits at the output. Write the configuration
// registers only while no beat is in flight.
module nearest_palette_color_mapper_core #(
	parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// entry_index[3:0], pixel_red[11:4], pixel_green[19:12], pixel_blue[27:20],
	// pixel_alpha[35:28], zero fill
	input logic [npcm_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// mode[0]
	input logic [0:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// result_red[7:0], result_green[15:8], result_blue[23:16], result_alpha[31:24],
	// chosen_index[35:32], zero fill
	output logic [npcm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// replaced[0]
	output logic [0:0] m_axis_tuser,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [npcm_pkg::DIST_W-1:0] cfg_data
);
	import npcm_pkg::*;

	logic advance;
	logic [COUNT_W-1:0] count_q;
	logic [DIST_W-1:0] near_enough_q;
	logic chain_valid [PALETTE_DEPTH+1];
	beat_t chain_beat [PALETTE_DEPTH+1];
	beat_t last;
	logic m_valid_q;
	rgb_t res_rgb_q;
	logic [COLOR_W-1:0] res_alpha_q;
	logic [IDX_W-1:0] res_idx_q;
	logic res_replaced_q;

	assign advance = !m_valid_q || m_axis_tready;
	assign s_axis_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			near_enough_q <= NEAR_ENOUGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index[0])
				REG_PALETTE_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				REG_NEAR_ENOUGH: near_enough_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		chain_beat[0] = '0;
		chain_beat[0].mode = s_axis_tuser[0];
		chain_beat[0].idx = s_axis_tdata[3:0];
		chain_beat[0].pixel.red = s_axis_tdata[11:4];
		chain_beat[0].pixel.green = s_axis_tdata[19:12];
		chain_beat[0].pixel.blue = s_axis_tdata[27:20];
		chain_beat[0].alpha = s_axis_tdata[35:28];
	end
	assign chain_valid[0] = s_axis_tvalid;

	for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
		npcm_cell #(
			.CELL_INDEX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.advance(advance),
			.count(count_q),
			.near_enough_sq(near_enough_q),
			.in_valid(chain_valid[i]),
			.in_beat(chain_beat[i]),
			.out_valid(chain_valid[i+1]),
			.out_beat(chain_beat[i+1])
		);
	end

	assign last = chain_beat[PALETTE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= chain_valid[PALETTE_DEPTH] && last.mode == MODE_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (last.found) begin
				res_rgb_q <= last.best_rgb;
				res_alpha_q <= ALPHA_OPAQUE;
				res_idx_q <= last.best_idx;
				res_replaced_q <= 1'b1;
			end else begin
				res_rgb_q <= last.pixel;
				res_alpha_q <= last.alpha;
				res_idx_q <= '0;
				res_replaced_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {4'b0000, res_idx_q, res_alpha_q, res_rgb_q.blue,
		res_rgb_q.green, res_rgb_q.red};
	assign m_axis_tuser = res_replaced_q;

`ifndef SYNTH
	a_kept_has_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[35:32] == '0)
		else $error("unreplaced pixel carries a nonzero index");

	a_replaced_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:24] == ALPHA_OPAQUE)
		else $error("replaced pixel is not opaque");

	a_empty_palette_passes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && count_q == '0 |-> !m_axis_tuser[0])
		else $error("pixel replaced with an empty palette");

	a_stall_holds_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(res_replaced_q))
		else $error("result lost while stalled");
`endif

endmodule
